@@ sv/asr_pkg.sv @@
// Shared types, widths and codes for the attack/sustain/release speed ramp.
package asr_pkg;

  localparam int SpeedW = 24;
  localparam int DirW   = 16;
  localparam int MoveW  = 25;
  localparam int PhaseW = 3;
  localparam int FracSh = 15;
  localparam int ProdW  = DirW + SpeedW + 1;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam int InDataW  = 8;
  localparam int OutDataW = 104;

  typedef logic [SpeedW-1:0]        speed_t;
  typedef logic signed [DirW-1:0]   dir_t;
  typedef logic signed [MoveW-1:0]  move_t;
  typedef logic [PhaseW-1:0]        phase_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;

  // Phase codes
  localparam phase_t PH_OFF     = 3'd0;
  localparam phase_t PH_TRIG_A  = 3'd1;
  localparam phase_t PH_ATTACK  = 3'd2;
  localparam phase_t PH_SUSTAIN = 3'd3;
  localparam phase_t PH_TRIG_R  = 3'd4;
  localparam phase_t PH_RELEASE = 3'd5;

  // Register indexes
  localparam cfg_idx_t REG_ATTACK_STEP  = 3'd0;
  localparam cfg_idx_t REG_RELEASE_STEP = 3'd1;
  localparam cfg_idx_t REG_MAX_SPEED    = 3'd2;
  localparam cfg_idx_t REG_DIR_X        = 3'd3;
  localparam cfg_idx_t REG_DIR_Y        = 3'd4;
  localparam cfg_idx_t REG_DIR_Z        = 3'd5;

  // Envelope stage to scaling stage
  typedef struct packed {
    logic   valid;
    speed_t speed;
    phase_t phase;
  } env_out_t;

endpackage

@@ sv/attack_sustain_release_speed_ramp_core.sv @@
// Top level of the attack/sustain/release speed ramp with motion vector output.
//
//  channel  | direction | handshake         | contents
//  ---------+-----------+-------------------+--------------------------------------
//  s_axis   | in        | s_tvalid/s_tready | key level for one frame tick
//  m_axis   | out       | m_tvalid/m_tready | motion vector, speed, phase, move flag
//  cfg      | in        | cfg_wen           | step sizes, max speed, direction
//
//  Each item sets the phase and speed at the edge it is accepted; while m_axis does not
//  stall, one item per cycle is sustained. The result is registered on its way to m_axis:
//  one register holds the updated envelope, the next holds the three products.
//  A stall on m_axis holds both stages; s_tready drops only once both are full.
//  Reset clears phase to off, speed and the config registers to zero, and empties the pipe.
module attack_sustain_release_speed_ramp_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [asr_pkg::InDataW-1:0]   s_tdata,   // [0] key_down
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [asr_pkg::OutDataW-1:0]  m_tdata,   // move_x, move_y, move_z,
                                                   // speed_now, phase_now, zero pad
  output logic                          m_tuser,   // [0] move_valid
  input  logic                          cfg_wen,
  input  asr_pkg::cfg_idx_t             cfg_idx,
  input  logic [asr_pkg::CfgDataW-1:0]  cfg_wdata
);
  import asr_pkg::*;

  speed_t   attack_step;
  speed_t   release_step;
  speed_t   speed_cap;
  dir_t     dir_x;
  dir_t     dir_y;
  dir_t     dir_z;

  env_out_t env;
  logic     down_ready;
  move_t    move_x;
  move_t    move_y;
  move_t    move_z;
  speed_t   speed_now;
  phase_t   phase_now;

  // Config registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step  <= '0;
      release_step <= '0;
      speed_cap    <= '0;
      dir_x        <= '0;
      dir_y        <= '0;
      dir_z        <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_ATTACK_STEP:  attack_step  <= cfg_wdata[SpeedW-1:0];
        REG_RELEASE_STEP: release_step <= cfg_wdata[SpeedW-1:0];
        REG_MAX_SPEED:    speed_cap    <= cfg_wdata[SpeedW-1:0];
        REG_DIR_X:        dir_x        <= $signed(cfg_wdata[DirW-1:0]);
        REG_DIR_Y:        dir_y        <= $signed(cfg_wdata[DirW-1:0]);
        REG_DIR_Z:        dir_z        <= $signed(cfg_wdata[DirW-1:0]);
        default: ;
      endcase
    end
  end

  asr_env u_env (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .key          (s_tdata[0]),
    .in_ready     (s_tready),
    .down_ready   (down_ready),
    .attack_step  (attack_step),
    .release_step (release_step),
    .speed_cap    (speed_cap),
    .env          (env)
  );

  asr_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .env        (env),
    .up_ready   (down_ready),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .move_valid (m_tuser),
    .move_x     (move_x),
    .move_y     (move_y),
    .move_z     (move_z),
    .speed_now  (speed_now),
    .phase_now  (phase_now)
  );

  // Pack: x [24:0], y [49:25], z [74:50], speed [98:75], phase [101:99]
  assign m_tdata = {2'b00, phase_now, speed_now, move_z, move_y, move_x};

endmodule

@@ sv/asr_env.sv @@
// Envelope phase machine and speed accumulator, one update per accepted item.
module asr_env (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              key,
  output logic              in_ready,
  input  logic              down_ready,
  input  asr_pkg::speed_t   attack_step,
  input  asr_pkg::speed_t   release_step,
  input  asr_pkg::speed_t   speed_cap,
  output asr_pkg::env_out_t env
);
  import asr_pkg::*;

  logic   valid;
  phase_t phase;
  phase_t phase_next;
  speed_t speed;
  speed_t speed_next;
  logic   acc;
  logic [SpeedW:0] att_sum;

  // the state registers double as this stage's payload
  assign in_ready = !valid || down_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    unique case (phase)
      PH_TRIG_A:  phase_next = PH_ATTACK;
      PH_ATTACK: begin
        if (!key)                    phase_next = PH_TRIG_R;
        else if (speed >= speed_cap) phase_next = PH_SUSTAIN;
        else                         phase_next = PH_ATTACK;
      end
      PH_SUSTAIN: phase_next = key ? PH_SUSTAIN : PH_TRIG_R;
      PH_TRIG_R:  phase_next = PH_RELEASE;
      PH_RELEASE: begin
        if (key)              phase_next = PH_TRIG_A;
        else if (speed == '0) phase_next = PH_OFF;
        else                  phase_next = PH_RELEASE;
      end
      default:    phase_next = key ? PH_TRIG_A : PH_OFF;  // off and unused codes
    endcase
  end

  assign att_sum = {1'b0, speed} + {1'b0, attack_step};

  always_comb begin
    unique case (phase_next)
      PH_OFF:     speed_next = '0;
      PH_ATTACK:  speed_next = (att_sum > {1'b0, speed_cap}) ? speed_cap
                                                            : att_sum[SpeedW-1:0];
      PH_RELEASE: speed_next = (speed >= release_step) ? speed - release_step : '0;
      default:    speed_next = speed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= PH_OFF;
      speed <= '0;
    end else begin
      if (in_ready) valid <= in_valid;
      if (acc) begin
        phase <= phase_next;
        speed <= speed_next;
      end
    end
  end

  assign env = '{valid: valid, speed: speed, phase: phase};

  a_trig_to_attack: assert property (@(posedge clk) disable iff (rst)
    (acc && phase == PH_TRIG_A) |=> phase == PH_ATTACK)
    else $error("attack trigger did not lead to attack");

  a_off_no_speed: assert property (@(posedge clk) disable iff (rst)
    acc |=> (phase != PH_OFF || speed == '0))
    else $error("speed left nonzero in off");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !acc |=> ($stable(speed) && $stable(phase)))
    else $error("state changed without an accepted item");

endmodule

@@ sv/asr_scale.sv @@
// Direction times speed products and the result register.
module asr_scale (
  input  logic              clk,
  input  logic              rst,
  input  asr_pkg::env_out_t env,
  output logic              up_ready,
  input  asr_pkg::dir_t     dir_x,
  input  asr_pkg::dir_t     dir_y,
  input  asr_pkg::dir_t     dir_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              move_valid,
  output asr_pkg::move_t    move_x,
  output asr_pkg::move_t    move_y,
  output asr_pkg::move_t    move_z,
  output asr_pkg::speed_t   speed_now,
  output asr_pkg::phase_t   phase_now
);
  import asr_pkg::*;

  logic signed [SpeedW:0]  spd_s;
  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;
  logic signed [ProdW-1:0] prod_z;

  assign up_ready = !out_valid || out_ready;

  // speed is nonnegative, so one zero bit makes it a signed operand
  assign spd_s  = $signed({1'b0, env.speed});
  assign prod_x = ProdW'(dir_x * spd_s);
  assign prod_y = ProdW'(dir_y * spd_s);
  assign prod_z = ProdW'(dir_z * spd_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= env.valid;
    end
  end

  // floor shift: drop the low fraction bits
  always_ff @(posedge clk) begin
    if (up_ready) begin
      move_valid <= (env.speed != '0);
      move_x     <= prod_x[FracSh +: MoveW];
      move_y     <= prod_y[FracSh +: MoveW];
      move_z     <= prod_z[FracSh +: MoveW];
      speed_now  <= env.speed;
      phase_now  <= env.phase;
    end
  end

  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (move_valid == (speed_now != '0)))
    else $error("move flag disagrees with speed");

  a_still_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && speed_now == '0) |-> (move_x == '0 && move_y == '0 && move_z == '0))
    else $error("motion given at zero speed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({move_valid, move_x, move_y, move_z, speed_now, phase_now})))
    else $error("result changed while stalled");

endmodule

@@ tb/tb_attack_sustain_release_speed_ramp_core.sv @@
// Self-checking testbench for the attack/sustain/release speed ramp core.
module tb_attack_sustain_release_speed_ramp_core;
  import asr_pkg::*;

  // m_tdata layout, lowest bit up: move_x, move_y, move_z, speed_now, phase_now, pad
  localparam int XLo     = 0;
  localparam int YLo     = XLo + MoveW;
  localparam int ZLo     = YLo + MoveW;
  localparam int SpdLo   = ZLo + MoveW;
  localparam int PhLo    = SpdLo + SpeedW;
  localparam int StallLimit = 3000;   // cycles with no item moving on either side
  localparam int LongHold   = 300;    // receiver hold-off, enough to fill the pipe

  typedef struct packed {
    logic   valid;
    move_t  mx;
    move_t  my;
    move_t  mz;
    speed_t speed;
    phase_t phase;
  } motion_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;
  logic cfg_wen = 1'b0;
  cfg_idx_t cfg_idx = REG_ATTACK_STEP;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  attack_sustain_release_speed_ramp_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Envelope shadow: configuration as last written, plus phase and speed
  speed_t atk_step = '0;
  speed_t rel_step = '0;
  speed_t top_speed = '0;
  dir_t   dir_x = '0;
  dir_t   dir_y = '0;
  dir_t   dir_z = '0;
  phase_t env_phase = PH_OFF;
  speed_t env_speed = '0;

  logic    key_q[$];        // key levels waiting to be offered
  motion_t motion_q[$];     // predicted results, oldest first

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_req = 0;        // long hold-off request, picked up by the receiver
  int stall_left = 0;
  logic key_fire = 1'b0;    // an item went in at the last rising edge
  int err_cnt = 0;
  int keys_in = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  logic [7:0] phases_seen = '0;
  int moving_results = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // (dir * speed) >> 15, arithmetic, so it floors
  function automatic move_t scale_dir(dir_t d, speed_t s);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] shifted;
    prod = d * $signed({1'b0, s});
    shifted = prod >>> FracSh;
    return shifted[MoveW-1:0];
  endfunction

  // One frame tick: phase moves on the old speed, then the phase acts on the speed.
  function automatic motion_t step_envelope(logic key);
    phase_t nxt;
    logic [SpeedW:0] sum;
    motion_t res;
    case (env_phase)
      PH_TRIG_A: nxt = PH_ATTACK;
      PH_ATTACK: begin
        if (!key) nxt = PH_TRIG_R;
        else nxt = (env_speed >= top_speed) ? PH_SUSTAIN : PH_ATTACK;
      end
      PH_SUSTAIN: nxt = key ? PH_SUSTAIN : PH_TRIG_R;
      PH_TRIG_R: nxt = PH_RELEASE;
      PH_RELEASE: begin
        if (key) nxt = PH_TRIG_A;
        else nxt = (env_speed == '0) ? PH_OFF : PH_RELEASE;
      end
      default: nxt = key ? PH_TRIG_A : PH_OFF;   // off, and the two unused codes
    endcase
    env_phase = nxt;
    if (nxt == PH_OFF) begin
      env_speed = '0;
    end else if (nxt == PH_ATTACK) begin
      sum = env_speed + atk_step;
      env_speed = (sum > top_speed) ? top_speed : sum[SpeedW-1:0];   // attack clamp
    end else if (nxt == PH_RELEASE) begin
      env_speed = (env_speed >= rel_step) ? env_speed - rel_step : '0;  // floor at zero
    end
    res.valid = (env_speed != '0);
    res.mx = res.valid ? scale_dir(dir_x, env_speed) : '0;
    res.my = res.valid ? scale_dir(dir_y, env_speed) : '0;
    res.mz = res.valid ? scale_dir(dir_z, env_speed) : '0;
    res.speed = env_speed;
    res.phase = env_phase;
    return res;
  endfunction

  function automatic void check_field(string fname, logic [MoveW-1:0] want,
                                      logic [MoveW-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
    end
  endfunction

  // Driver: offers the next key level at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || key_fire) begin
      if (key_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {{(InDataW-1){1'b0}}, key_q.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req = 0;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Monitor: checks results first, then predicts for the item taken at this edge.
  // A result never comes out at the edge its own item goes in.
  always @(posedge clk) begin
    motion_t want;
    motion_t got;
    key_fire = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.valid = m_tuser;
        got.mx = m_tdata[XLo +: MoveW];
        got.my = m_tdata[YLo +: MoveW];
        got.mz = m_tdata[ZLo +: MoveW];
        got.speed = m_tdata[SpdLo +: SpeedW];
        got.phase = m_tdata[PhLo +: PhaseW];
        results_seen++;
        if (motion_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item on m_axis, actual %h / %b", $time, m_tdata, m_tuser);
        end else begin
          want = motion_q.pop_front();
          check_field("move_valid", MoveW'(want.valid), MoveW'(got.valid));
          check_field("move_x", want.mx, got.mx);
          check_field("move_y", want.my, got.my);
          check_field("move_z", want.mz, got.mz);
          check_field("speed_now", MoveW'(want.speed), MoveW'(got.speed));
          check_field("phase_now", MoveW'(want.phase), MoveW'(got.phase));
        end
      end
      if (s_tvalid && s_tready) begin
        key_fire = 1'b1;
        keys_in++;
        want = step_envelope(s_tdata[0]);
        phases_seen[want.phase] = 1'b1;
        if (want.valid) moving_results++;
        motion_q.push_back(want);
      end
      // watchdog
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Register write, one per falling edge; the shadow follows at once since the pipe is idle
  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ATTACK_STEP:  atk_step = val;
      REG_RELEASE_STEP: rel_step = val;
      REG_MAX_SPEED:    top_speed = val;
      REG_DIR_X:        dir_x = val[DirW-1:0];
      REG_DIR_Y:        dir_y = val[DirW-1:0];
      REG_DIR_Z:        dir_z = val[DirW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_profile(speed_t up, speed_t down, speed_t top, dir_t dx, dir_t dy,
                              dir_t dz);
    write_reg(REG_ATTACK_STEP, up);
    write_reg(REG_RELEASE_STEP, down);
    write_reg(REG_MAX_SPEED, top);
    // upper byte of a direction write is ignored, so put noise there
    write_reg(REG_DIR_X, {8'($urandom), dx});
    write_reg(REG_DIR_Y, {8'($urandom), dy});
    write_reg(REG_DIR_Z, {8'($urandom), dz});
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic dir_t pick_dir();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'shFFFF;   // -1 LSB, exercises floor rounding
      default: return dir_t'($urandom);
    endcase
  endfunction

  task automatic load_random_profile();
    speed_t top;
    speed_t up;
    speed_t down;
    top = speed_t'($urandom_range(1, 24'hFFFFFF));
    up = top / speed_t'($urandom_range(1, 16)) + speed_t'($urandom_range(0, 255));
    down = top / speed_t'($urandom_range(1, 16)) + speed_t'($urandom_range(0, 255));
    case ($urandom_range(7))
      0: begin top = '1; up = '1; down = '1; end   // all at full scale
      1: top = '0;                                 // sustain at standstill
      2: up = '0;                                  // attack never moves
      3: down = '0;                                // release never ends
      4: begin up = '1; down = 24'd1; end          // jump up, crawl down
      default: ;
    endcase
    load_profile(up, down, top, pick_dir(), pick_dir(), pick_dir());
  endtask

  // Pushes len key levels, bit 0 first
  task automatic push_pattern(logic [31:0] bits, int len);
    for (int i = 0; i < len; i++) key_q.push_back(bits[i]);
  endtask

  // Mostly hold/release runs so the ramp reaches sustain and runs out in release;
  // the rest is key chatter. The last run is cut to land on exactly n items.
  task automatic queue_keys(int n);
    int target;
    int run;
    target = key_q.size() + n;
    while (key_q.size() < target) begin
      if ($urandom_range(9) < 8) begin
        run = $urandom_range(1, 30);
        repeat (run) key_q.push_back(1'b1);
        run = $urandom_range(1, 30);
        repeat (run) key_q.push_back(1'b0);
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) key_q.push_back(1'($urandom));
      end
    end
    while (key_q.size() > target) void'(key_q.pop_back());
  endtask

  // Waits until every queued item went in and every result came back
  task automatic wait_drained();
    do @(negedge clk);
    while (key_q.size() > 0 || s_tvalid || motion_q.size() > 0);
    repeat (3) @(negedge clk);
  endtask

  // Random block with a full stop halfway; optionally a long receiver hold-off first
  task automatic run_block(int n, bit hold);
    load_random_profile();
    if (hold) stall_req = LongHold;
    queue_keys(n / 2);
    wait_drained();
    queue_keys(n - n / 2);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ramp with overshoot clamp, sustain, release exactly to zero, off, a short tap,
    // a re-press in the release trigger, release undershoot to zero. Floor rounding via dir_z = -1.
    src_idle_pct = 22;
    snk_idle_pct = 53;
    load_profile(24'h014000, 24'h018000, 24'h030000, 16'sh8000, 16'sh7FFF, 16'shFFFF);
    push_pattern(32'b0000_1011_0000_0111_1111_00, 18);
    wait_drained();
    // Directed: full-scale steps and speed, zero release step holds the speed
    load_profile(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 16'sh7FFF, 16'sh8000, 16'sh0001);
    push_pattern(32'b1_0000_111, 8);
    wait_drained();

    // Random part, three idling mixes
    run_block(70, 1'b1);
    run_block(70, 1'b0);
    run_block(70, 1'b0);
    src_idle_pct = 53;
    snk_idle_pct = 22;
    run_block(70, 1'b0);
    run_block(70, 1'b1);
    run_block(70, 1'b0);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_block(70, 1'b0);
    run_block(70, 1'b0);
    run_block(70, 1'b0);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d key items and %0d results (%0d with motion), phases seen %b",
             keys_in, results_seen, moving_results, phases_seen[5:0]);
    $display("under varied back-pressure, long receiver hold-offs and register profiles");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/asr_pkg.sv
sv/asr_env.sv
sv/asr_scale.sv
sv/attack_sustain_release_speed_ramp_core.sv
tb/tb_attack_sustain_release_speed_ramp_core.sv
